// File: sv/des_pkg.sv
// des_pkg: shared types and constants for the delayed event scheduler.
// Used by des_cell, des_chain and delayed_event_scheduler. No dependencies.
`timescale 1ns / 1ps

package des_pkg;

	localparam int TIME_W  = 32;
	localparam int EVENT_W = 8;
	localparam int DELAY_W = 16;

	// results released by one tick at most
	localparam int MAX_RESULTS = 16;
	localparam int RES_W       = $clog2(MAX_RESULTS);

	typedef logic [1:0] status_t;
	localparam status_t ST_EXEC = 2'd0;
	localparam status_t ST_LATE = 2'd1;
	localparam status_t ST_FULL = 2'd2;

	localparam logic REQ_EVENT = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0]  due;
		logic [EVENT_W-1:0] ev;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} chain_ctrl_t;

endpackage

// File: sv/des_cell.sv
// des_cell: one slot of the time-sorted chain.
// Depends on des_pkg (entry_t, chain_ctrl_t).
`timescale 1ns / 1ps

module des_cell (
	input  logic                 clk,
	input  logic                 occ,
	input  logic                 prev_keep,
	input  des_pkg::entry_t      prev_d,
	input  des_pkg::entry_t      next_d,
	input  des_pkg::entry_t      new_d,
	input  des_pkg::chain_ctrl_t ctrl,
	output logic                 keep,
	output des_pkg::entry_t      d
);

	des_pkg::entry_t d_q;

	// entry stays put on insert when it is due at or before the new one
	assign keep = occ && (d_q.due <= new_d.due);
	assign d    = d_q;

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			d_q <= next_d;
		end else if (ctrl.insert && !keep) begin
			d_q <= prev_keep ? new_d : prev_d;
		end
	end

endmodule

// File: sv/des_chain.sv
// des_chain: row of des_cell slots plus the fill count.
// Depends on des_pkg and des_cell.
`timescale 1ns / 1ps

module des_chain #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  des_pkg::chain_ctrl_t        ctrl,
	input  des_pkg::entry_t             new_d,
	output logic [$clog2(DEPTH+1)-1:0]  count,
	output des_pkg::entry_t             head,
	output des_pkg::entry_t             second
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]   count_q;
	logic [DEPTH-1:0] occ;
	logic [DEPTH-1:0] keep;
	des_pkg::entry_t d [DEPTH];

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			des_pkg::entry_t prev_d;
			des_pkg::entry_t next_d;
			logic            prev_keep;

			assign occ[i] = count_q > CW'(i);

			if (i == 0) begin : g_first
				assign prev_d    = new_d;
				assign prev_keep = 1'b1;
			end else begin : g_mid
				assign prev_d    = d[i-1];
				assign prev_keep = keep[i-1];
			end

			if (i == DEPTH - 1) begin : g_last
				assign next_d = d[i];
			end else begin : g_inner
				assign next_d = d[i+1];
			end

			des_cell u_cell (
				.clk       (clk),
				.occ       (occ[i]),
				.prev_keep (prev_keep),
				.prev_d    (prev_d),
				.next_d    (next_d),
				.new_d     (new_d),
				.ctrl      (ctrl),
				.keep      (keep[i]),
				.d         (d[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.insert) begin
			count_q <= count_q + CW'(1);
		end else if (ctrl.pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign count  = count_q;
	assign head   = d[0];
	assign second = d[1];

endmodule

// File: sv/delayed_event_scheduler.sv
// delayed_event_scheduler: lockstep event scheduler over a time-sorted cell chain.
// Depends on des_pkg and des_chain.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_stall   req_type, event_number, request_time, current_time
//   out      out  out_valid/out_stall out_event, status, last
//   cfg      in   cfg_we              cfg_wdata (lockstep_delay)
//
// An event request registers the due-time add at accept, then compares and
// inserts into the chain (or loads a result into the output register).
// A tick releases one due event per cycle while the output does not stall, and
// returns to idle when nothing is due; each release pops the chain head.
// Input stalls for the whole transaction; one output register.
// Reset clears control, delay and fill count; slot contents are not cleared.
`timescale 1ns / 1ps

module delayed_event_scheduler #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  event_number,
	input  logic [31:0] request_time,
	input  logic [31:0] current_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_event,
	output logic [1:0]  status,
	output logic        last
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_REQ  = 3'b010,
		S_POP  = 3'b100
	} state_t;

	state_t state_q;

	logic [des_pkg::DELAY_W-1:0]   delay_q;
	logic [des_pkg::TIME_W:0]      due_s1;
	logic [des_pkg::TIME_W-1:0]    now_s1;
	logic [des_pkg::EVENT_W-1:0]   ev_s1;
	logic [des_pkg::RES_W-1:0]     n_q;

	logic                          out_valid_q;
	logic [des_pkg::EVENT_W-1:0]   out_event_q;
	des_pkg::status_t              status_q;
	logic                          last_q;

	des_pkg::chain_ctrl_t ctrl;
	des_pkg::entry_t      new_d;
	des_pkg::entry_t      head;
	des_pkg::entry_t      second;
	logic [CW-1:0]        count;

	logic in_fire;
	logic load_ok;
	logic is_late;
	logic is_future;
	logic is_full;
	logic head_due;
	logic pop_last;
	logic emit;
	des_pkg::entry_t emit_d;
	des_pkg::status_t emit_st;
	logic emit_last;

	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign load_ok  = !out_valid_q || !out_stall;

	assign is_late   = due_s1 < {1'b0, now_s1};
	assign is_future = due_s1 > {1'b0, now_s1};
	assign is_full   = (count == CW'(QUEUE_DEPTH));

	assign head_due = (count != '0) && (head.due <= now_s1);
	assign pop_last = (n_q == des_pkg::RES_W'(des_pkg::MAX_RESULTS - 1))
		|| (count == CW'(1)) || (second.due > now_s1);

	// saturate due times past 32 bits
	assign new_d.due = due_s1[des_pkg::TIME_W] ? '1 : due_s1[des_pkg::TIME_W-1:0];
	assign new_d.ev  = ev_s1;

	always_comb begin
		ctrl      = '0;
		emit      = 1'b0;
		emit_d    = head;
		emit_st   = des_pkg::ST_EXEC;
		emit_last = 1'b1;
		unique case (state_q)
			S_REQ: begin
				emit_d.ev = ev_s1;
				if (is_future && !is_full) begin
					ctrl.insert = 1'b1;
				end else begin
					emit    = load_ok;
					emit_st = is_future ? des_pkg::ST_FULL :
						(is_late ? des_pkg::ST_LATE : des_pkg::ST_EXEC);
				end
			end
			S_POP: begin
				if (head_due && load_ok) begin
					emit      = 1'b1;
					emit_last = pop_last;
					ctrl.pop  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			delay_q <= '0;
			n_q     <= '0;
		end else begin
			if (cfg_we) begin
				delay_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					n_q <= '0;
					if (in_fire) begin
						state_q <= (req_type == des_pkg::REQ_TICK) ? S_POP : S_REQ;
					end
				end
				S_REQ: begin
					if (ctrl.insert || emit) begin
						state_q <= S_IDLE;
					end
				end
				S_POP: begin
					if (!head_due || (emit && emit_last)) begin
						state_q <= S_IDLE;
					end
					if (emit) begin
						n_q <= n_q + des_pkg::RES_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			due_s1 <= {1'b0, request_time} + {{(des_pkg::TIME_W + 1 - des_pkg::DELAY_W){1'b0}},
				delay_q};
			now_s1 <= current_time;
			ev_s1  <= event_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_event_q <= emit_d.ev;
			status_q    <= emit_st;
			last_q      <= emit_last;
		end
	end

	des_chain #(
		.DEPTH (QUEUE_DEPTH)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.new_d  (new_d),
		.count  (count),
		.head   (head),
		.second (second)
	);

	assign out_valid = out_valid_q;
	assign out_event = out_event_q;
	assign status    = status_q;
	assign last      = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(QUEUE_DEPTH))
		else $error("fill count beyond queue depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("accepted transaction left block idle");

	a_last_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.pop && count == CW'(1)) |=> (out_valid_q && last_q && count == '0))
		else $error("emptying pop not flagged last");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!ctrl.insert && !ctrl.pop) |=> count == $past(count))
		else $error("fill count moved without insert or pop");

endmodule

// File: verif/tb_delayed_event_scheduler.sv
// tb_delayed_event_scheduler: self-checking testbench for the delayed event scheduler.
// Predicts executed, late and overflow results and tick releases from a local sorted store.
// Depends on des_pkg and delayed_event_scheduler.
`timescale 1ns / 1ps

module tb_delayed_event_scheduler;

	localparam int SLOTS = 16;

	typedef struct packed {
		logic [des_pkg::EVENT_W-1:0] ev;
		des_pkg::status_t            st;
		logic                        last;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic        req_type;
	logic [7:0]  event_number;
	logic [31:0] request_time;
	logic [31:0] current_time;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_event;
	logic [1:0]  status;
	logic        last;

	// predictor state
	logic [des_pkg::DELAY_W-1:0] sched_delay;
	des_pkg::entry_t             sched_store[$];
	result_t                     expected_results[$];

	int          mismatches;
	int          idle_pct;
	logic [31:0] clock_now;

	delayed_event_scheduler #(.QUEUE_DEPTH(SLOTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.event_number(event_number),
		.request_time(request_time),
		.current_time(current_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_event(out_event),
		.status(status),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("%0t: mismatch: %s", $realtime, msg);
	endtask

	function automatic void push_result(logic [7:0] ev, des_pkg::status_t st, logic fin);
		result_t r;
		r.ev = ev;
		r.st = st;
		r.last = fin;
		expected_results.push_back(r);
	endfunction

	function automatic void predict_schedule(logic kind, logic [7:0] ev, logic [31:0] req,
						 logic [31:0] now);
		logic [32:0]     due_wide;
		des_pkg::entry_t e;
		int              pos;
		int              n;
		logic            fin;
		if (kind == des_pkg::REQ_EVENT) begin
			due_wide = {1'b0, req} + {17'd0, sched_delay};
			if (due_wide > {1'b0, now}) begin
				if (sched_store.size() >= SLOTS) begin
					push_result(ev, des_pkg::ST_FULL, 1'b1);
				end else begin
					// sum past 32 bits saturates
					e.due = due_wide[32] ? '1 : due_wide[31:0];
					e.ev = ev;
					pos = 0;
					while (pos < sched_store.size() && sched_store[pos].due <= e.due)
						pos++;
					sched_store.insert(pos, e);
				end
			end else begin
				push_result(ev, (due_wide < {1'b0, now}) ? des_pkg::ST_LATE :
					des_pkg::ST_EXEC, 1'b1);
			end
		end else begin
			n = 0;
			while (n < des_pkg::MAX_RESULTS && sched_store.size() > 0 &&
			       sched_store[0].due <= now) begin
				e = sched_store.pop_front();
				n++;
				fin = (n == des_pkg::MAX_RESULTS) || (sched_store.size() == 0) ||
				      (sched_store[0].due > now);
				push_result(e.ev, des_pkg::ST_EXEC, fin);
			end
		end
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result event %0d status %0d",
							out_event, status));
			end else begin
				want = expected_results.pop_front();
				if (out_event !== want.ev)
					flag_mismatch($sformatf("out_event %0d, want %0d", out_event, want.ev));
				if (status !== want.st)
					flag_mismatch($sformatf("status %0d, want %0d (event %0d)",
								status, want.st, want.ev));
				if (last !== want.last)
					flag_mismatch($sformatf("last %0b, want %0b (event %0d)",
								last, want.last, want.ev));
			end
		end
	end

	// receiver backpressure in random bursts
	initial begin : drive_out_stall
		int burst;
		burst = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_pct == 0) begin
				burst = 0;
				out_stall = 1'b0;
			end else if (burst > 0) begin
				burst--;
				out_stall = 1'b1;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				burst = $urandom_range(0, 9);
				out_stall = 1'b1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	task automatic send_item(input logic kind, input logic [7:0] ev, input logic [31:0] req,
				 input logic [31:0] now);
		int gap;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_type = kind;
		event_number = ev;
		request_time = req;
		current_time = now;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_schedule(kind, ev, req, now);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		// a queued request gives no result, let the insert finish
		repeat (6) @(posedge clk);
	endtask

	task automatic set_delay(input logic [15:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		sched_delay = value;
	endtask

	// delay 0 out of reset: executed, late, queued with a tie, tick releases
	task automatic test_basic_outcomes();
		send_item(des_pkg::REQ_EVENT, 8'h00, 32'd100, 32'd100);
		send_item(des_pkg::REQ_EVENT, 8'hFF, 32'd0, 32'hFFFF_FFFF);
		send_item(des_pkg::REQ_EVENT, 8'hA5, 32'd150, 32'd100);
		send_item(des_pkg::REQ_EVENT, 8'h11, 32'd150, 32'd100);
		send_item(des_pkg::REQ_EVENT, 8'h5A, 32'd140, 32'd100);
		send_item(des_pkg::REQ_TICK, 8'h00, 32'd0, 32'd139);
		send_item(des_pkg::REQ_TICK, 8'hFF, 32'hFFFF_FFFF, 32'd150);
	endtask

	// due time past 32 bits is held at the top of the time range
	task automatic test_saturated_due();
		set_delay(16'hFFFF);
		send_item(des_pkg::REQ_EVENT, 8'h3C, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(des_pkg::REQ_EVENT, 8'hC3, 32'hFFFF_0000, 32'hFFFF_FFFF);
		send_item(des_pkg::REQ_TICK, 8'h00, 32'd0, 32'hFFFF_FFFE);
		send_item(des_pkg::REQ_TICK, 8'h00, 32'd0, 32'hFFFF_FFFF);
	endtask

	// fill the store, overflow once, then release the whole store on one tick
	task automatic test_full_store();
		int i;
		set_delay(16'd1);
		for (i = 0; i <= SLOTS; i++)
			send_item(des_pkg::REQ_EVENT, 8'(i + 1), 32'd1000, 32'd0);
		send_item(des_pkg::REQ_TICK, 8'h00, 32'd0, 32'd1001);
	endtask

	task automatic test_random_traffic(input int count);
		int       i;
		int       pick;
		longint   target;
		logic [7:0] ev;
		for (i = 0; i < count; i++) begin
			if (i % 30 == 0 && idle_pct != 0) begin
				pick = $urandom_range(0, 2);
				idle_pct = (pick == 0) ? 1 : (pick == 1) ? 15 : 40;
			end
			ev = 8'($urandom_range(0, 255));
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				// request due a little before or after the running time
				target = longint'(clock_now) + $urandom_range(0, 24) - 4 - sched_delay;
				if (target < 0)
					target = 0;
				send_item(des_pkg::REQ_EVENT, ev, 32'(target), clock_now);
			end else if (pick < 80) begin
				clock_now = clock_now + $urandom_range(0, 6);
				send_item(des_pkg::REQ_TICK, ev, $urandom, clock_now);
			end else if (pick < 95) begin
				send_item(1'($urandom_range(0, 1)), ev, $urandom, $urandom);
			end else if (pick < 98) begin
				send_item(des_pkg::REQ_TICK, ev, $urandom, 32'hFFFF_FFFF);
			end else begin
				send_item(des_pkg::REQ_EVENT, ev, $urandom, clock_now);
				wait_drained();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		req_type = des_pkg::REQ_EVENT;
		event_number = '0;
		request_time = '0;
		current_time = '0;
		sched_delay = '0;
		mismatches = 0;
		idle_pct = 15;
		clock_now = 32'($urandom_range(1000, 1 << 20));
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_outcomes();
		test_saturated_due();
		test_full_store();

		set_delay(16'd0);
		test_random_traffic(86);
		set_delay(16'hFFFF);
		test_random_traffic(86);
		set_delay(16'($urandom_range(0, 65535)));
		test_random_traffic(86);
		set_delay(16'd7);
		test_random_traffic(86);
		set_delay(16'($urandom_range(0, 65535)));
		idle_pct = 0;
		test_random_traffic(86);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
